// ----- hw/rtl/clf_pkg.sv -----
// ----------------------------------------------------------------------------
// clf_pkg
// Shared constants, types and tables for the cross-channel lrn forward block.
// ----------------------------------------------------------------------------
package clf_pkg;

    // channel limits and field widths
    localparam int MAX_WINDOW   = 15;
    localparam int MAX_CHANNELS = 4096;
    localparam int CNT_W        = $clog2(MAX_CHANNELS) + 1;
    localparam int RING_DEPTH   = 16;
    localparam int RING_AW      = $clog2(RING_DEPTH);

    // configuration register indexes
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_BIAS   = 2'd1;
    localparam logic [1:0] REG_ALPHA  = 2'd2;
    localparam logic [1:0] REG_BETA   = 2'd3;

    // configuration reset values
    localparam logic [3:0]  WINDOW_RST = 4'd5;
    localparam logic [23:0] BIAS_RST   = 24'd131072;
    localparam logic [23:0] ALPHA_RST  = 24'd1678;
    localparam logic [15:0] BETA_RST   = 16'd12288;

    typedef logic [15:0][31:0] root_tab_t;

    // integer square root, elaboration time only
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bv;
        n   = n_in;
        res = 64'd0;
        bv  = 64'd1 << 62;
        while (bv > n) bv = bv >> 2;
        while (bv != 64'd0) begin
            if (n >= res + bv) begin
                n   = n - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    // successive roots 2^(2^-n) in q1.30
    function automatic root_tab_t make_roots();
        root_tab_t   t;
        logic [63:0] r;
        r    = isqrt64(64'd1 << 61);
        t[0] = r[31:0];
        for (int i = 1; i < 16; i++) begin
            r    = isqrt64({r[33:0], 30'd0});
            t[i] = r[31:0];
        end
        return t;
    endfunction

    localparam root_tab_t EXP2_ROOTS = make_roots();

endpackage

// ----- hw/rtl/cross_channel_lrn_forward.sv -----
// ----------------------------------------------------------------------------
// cross_channel_lrn_forward
// Local response normalization across channels, one spatial position at a
// time, built around one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one activation per item, channel order, last one flagged.
//   m_ channel: normalized value, scale, channel index and run end flag.
//   cfg_ port: write enable, register index, data; taken at once. Write it
//   only while the block is idle; the block itself does not enforce this.
// Sequence:
//   an item is taken and then the block checks which results are due, at
//   most eight per item. Each result runs the sequencer: window sum (one
//   ring read per channel), two partial products, a 34 step division by
//   the window, a normalizing shift of up to 31 steps, 16 log steps, one
//   beta product, 16 exp steps and a rounding step; every step after the
//   division is skipped when the value, beta or scale is zero.
//   s_ready is high only in idle.
// Reset:
//   clears the channel counters and loads the default registers; the value
//   ring needs no clearing since every read entry was written first.
// Stall:
//   a result is held in the output registers until m_ready; the sequencer
//   waits there.
// ----------------------------------------------------------------------------
module cross_channel_lrn_forward
    import clf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample_value,
    input  logic               s_last_channel,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_norm_value,
    output logic [31:0]        m_scale_value,
    output logic [11:0]        m_channel_index,
    output logic               m_run_end,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_index,
    input  logic [23:0]        cfg_wr_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_GETV  = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_MUL0  = 4'd4;
    localparam logic [3:0] S_MUL1  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SCALE = 4'd7;
    localparam logic [3:0] S_LNORM = 4'd8;
    localparam logic [3:0] S_LOGIT = 4'd9;
    localparam logic [3:0] S_BETA  = 4'd10;
    localparam logic [3:0] S_EXP   = 4'd11;
    localparam logic [3:0] S_PROD  = 4'd12;
    localparam logic [3:0] S_ROUND = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]         state_reg, state_next;
    logic [3:0]         ws_reg, ws_next;
    logic [23:0]        k_reg, k_next;
    logic [23:0]        alpha_reg, alpha_next;
    logic [15:0]        beta_reg, beta_next;
    logic [CNT_W-1:0]   in_cnt_reg, in_cnt_next;
    logic [CNT_W-1:0]   out_cnt_reg, out_cnt_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic               last_reg, last_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [15:0]        v_reg, v_next;
    logic [33:0]        sum_reg, sum_next;
    logic [57:0]        acc_reg, acc_next;
    logic [33:0]        div_reg, div_next;
    logic [3:0]         rem_reg, rem_next;
    logic [5:0]         step_reg, step_next;
    logic [31:0]        scale_reg, scale_next;
    logic [31:0]        m_reg, m_next;
    logic [4:0]         p_reg, p_next;
    logic [15:0]        frac_reg, frac_next;
    logic signed [24:0] q_reg, q_next;
    logic [30:0]        g_reg, g_next;
    logic [15:0]        norm_reg, norm_next;

    // value ring
    logic [15:0]        ring_mem [RING_DEPTH];
    logic [15:0]        rd_data_reg;
    logic [RING_AW-1:0] rd_addr;
    logic               ring_we;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic               s_fire;
    logic [2:0]         half;
    logic [3:0]         w_eff;
    logic [CNT_W-1:0]   o_plus_half;
    logic [CNT_W-1:0]   lo_ch, hi_ch;
    logic               emit_ok;
    logic [16:0]        rd_mag, v_mag;
    logic [57:0]        mul_tot;
    logic [4:0]         div_t;
    logic [34:0]        scale_sum;
    logic [31:0]        scale_sat;
    logic [15:0]        sat_by_sign;
    logic [31:0]        log_t;
    logic signed [20:0] log_val;
    logic [21:0]        log_abs;
    logic signed [38:0] e_val;
    logic signed [8:0]  ip;
    logic signed [10:0] sh;
    logic [63:0]        rnd_sum;
    logic [63:0]        r_val;
    logic [15:0]        norm_fin;

    assign s_fire = s_valid && s_ready;
    assign half   = ws_reg[3:1];
    assign w_eff  = (ws_reg == 4'd0) ? 4'd1 : ws_reg;

    assign mul_p = mul_a * mul_b;

    // ring write on accept, registered read
    assign ring_we = s_fire;
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[in_cnt_reg[RING_AW-1:0]] <= s_sample_value;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    // window bounds for the next output channel
    always_comb begin
        o_plus_half = out_cnt_reg + CNT_W'(half);
        lo_ch   = (out_cnt_reg >= CNT_W'(half)) ? out_cnt_reg - CNT_W'(half) : '0;
        hi_ch   = (o_plus_half < n_reg) ? o_plus_half : n_reg;
        emit_ok = (cnt_reg < 4'd8) && (out_cnt_reg <= n_reg) &&
                  (last_reg || (o_plus_half <= n_reg));
    end

    // magnitudes
    assign rd_mag = rd_data_reg[15] ? 17'(-{1'b1, rd_data_reg}) : {1'b0, rd_data_reg};
    assign v_mag  = v_reg[15] ? 17'(-{1'b1, v_reg}) : {1'b0, v_reg};
    assign sat_by_sign = v_reg[15] ? 16'h8000 : 16'h7fff;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SUM: begin
                mul_a = 32'(rd_mag);
                mul_b = 32'(rd_mag);
            end
            S_MUL0: begin
                mul_a = 32'(alpha_reg);
                mul_b = 32'(sum_reg[16:0]);
            end
            S_MUL1: begin
                mul_a = 32'(alpha_reg);
                mul_b = 32'(sum_reg[33:17]);
            end
            S_LOGIT: begin
                mul_a = {1'b0, m_reg[30:0]};
                mul_b = {1'b0, m_reg[30:0]};
            end
            S_BETA: begin
                mul_a = 32'(beta_reg);
                mul_b = 32'(log_abs);
            end
            S_EXP: begin
                mul_a = {1'b0, g_reg};
                mul_b = EXP2_ROOTS[step_reg[3:0]];
            end
            S_PROD: begin
                mul_a = 32'(v_mag);
                mul_b = {1'b0, g_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // datapath helpers
    always_comb begin
        mul_tot   = acc_reg + {mul_p[40:0], 17'd0};
        div_t     = {rem_reg, div_reg[33]};
        scale_sum = 35'(k_reg) + 35'(div_reg);
        scale_sat = (scale_sum[34:32] != 3'd0) ? 32'hffff_ffff : scale_sum[31:0];
        log_t     = mul_p[61:30];
        log_val   = {~p_reg[4], p_reg[3:0], frac_reg};
        log_abs   = log_val[20] ? 22'(-log_val) : 22'(log_val);
        e_val     = log_val[20] ? 39'(mul_p[37:0]) : -39'(mul_p[37:0]);
        ip        = q_reg[24:16];
        sh        = 11'sd30 - 11'(ip);
        rnd_sum   = 64'(acc_reg[47:0]) + (64'd1 << 6'(sh - 11'sd1));
        if (ip >= 9'sd16) begin
            r_val = 64'd32768;
        end else if (sh >= 11'sd64) begin
            r_val = 64'd0;
        end else begin
            r_val = rnd_sum >> 6'(sh);
        end
        if (!v_reg[15]) begin
            norm_fin = (r_val > 64'd32767) ? 16'h7fff : r_val[15:0];
        end else begin
            norm_fin = (r_val > 64'd32768) ? 16'h8000 : 16'(-r_val[15:0]);
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        ws_next      = ws_reg;
        k_next       = k_reg;
        alpha_next   = alpha_reg;
        beta_next    = beta_reg;
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        n_next       = n_reg;
        last_next    = last_reg;
        cnt_next     = cnt_reg;
        j_next       = j_reg;
        hi_next      = hi_reg;
        v_next       = v_reg;
        sum_next     = sum_reg;
        acc_next     = acc_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        scale_next   = scale_reg;
        m_next       = m_reg;
        p_next       = p_reg;
        frac_next    = frac_reg;
        q_next       = q_reg;
        g_next       = g_reg;
        norm_next    = norm_reg;
        rd_addr      = j_reg[RING_AW-1:0];

        // configuration writes
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_WINDOW: ws_next    = cfg_wr_data[3:0];
                REG_BIAS:   k_next     = cfg_wr_data;
                REG_ALPHA:  alpha_next = cfg_wr_data;
                REG_BETA:   beta_next  = cfg_wr_data[15:0];
                default:    ws_next    = ws_reg;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    n_next      = in_cnt_reg;
                    last_next   = s_last_channel ||
                                  (in_cnt_reg >= CNT_W'(MAX_CHANNELS - 1));
                    in_cnt_next = in_cnt_reg + 1'b1;
                    cnt_next    = '0;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                rd_addr = out_cnt_reg[RING_AW-1:0];
                if (emit_ok) begin
                    j_next     = lo_ch;
                    hi_next    = hi_ch;
                    sum_next   = '0;
                    state_next = S_GETV;
                end else begin
                    if (last_reg) begin
                        in_cnt_next  = '0;
                        out_cnt_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_GETV: begin
                v_next     = rd_data_reg;
                state_next = S_SUM;
            end
            S_SUM: begin
                sum_next = sum_reg + 34'(mul_p[31:0]);
                rd_addr  = RING_AW'(j_reg + 1'b1);
                if (j_reg == hi_reg) begin
                    state_next = S_MUL0;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_MUL0: begin
                acc_next   = mul_p[57:0];
                state_next = S_MUL1;
            end
            S_MUL1: begin
                div_next   = mul_tot[57:24];
                rem_next   = '0;
                step_next  = 6'd33;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_t >= {1'b0, w_eff}) begin
                    rem_next = 4'(div_t - {1'b0, w_eff});
                    div_next = {div_reg[32:0], 1'b1};
                end else begin
                    rem_next = div_t[3:0];
                    div_next = {div_reg[32:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == 6'd0) begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE: begin
                scale_next = scale_sat;
                if (v_reg == 16'd0) begin
                    norm_next  = '0;
                    state_next = S_OUT;
                end else if (beta_reg == 16'd0) begin
                    norm_next  = v_reg;
                    state_next = S_OUT;
                end else if (scale_sat == 32'd0) begin
                    norm_next  = sat_by_sign;
                    state_next = S_OUT;
                end else begin
                    m_next     = scale_sat;
                    p_next     = 5'd31;
                    state_next = S_LNORM;
                end
            end
            S_LNORM: begin
                if (m_reg[31]) begin
                    m_next     = {1'b0, m_reg[31:1]};
                    frac_next  = '0;
                    step_next  = 6'd15;
                    state_next = S_LOGIT;
                end else begin
                    m_next = {m_reg[30:0], 1'b0};
                    p_next = p_reg - 1'b1;
                end
            end
            S_LOGIT: begin
                frac_next = {frac_reg[14:0], log_t[31]};
                m_next    = log_t[31] ? {1'b0, log_t[31:1]} : log_t;
                step_next = step_reg - 1'b1;
                if (step_reg == 6'd0) begin
                    state_next = S_BETA;
                end
            end
            S_BETA: begin
                q_next     = 25'(e_val >>> 14);
                g_next     = 31'd1 << 30;
                step_next  = '0;
                state_next = S_EXP;
            end
            S_EXP: begin
                if (q_reg[4'd15 - step_reg[3:0]]) begin
                    g_next = mul_p[60:30];
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 6'd15) begin
                    state_next = S_PROD;
                end
            end
            S_PROD: begin
                acc_next   = 58'(mul_p[47:0]);
                state_next = S_ROUND;
            end
            S_ROUND: begin
                norm_next  = norm_fin;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    out_cnt_next = out_cnt_reg + 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    state_next   = S_CHECK;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ws_reg      <= WINDOW_RST;
            k_reg       <= BIAS_RST;
            alpha_reg   <= ALPHA_RST;
            beta_reg    <= BETA_RST;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            last_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            ws_reg      <= ws_next;
            k_reg       <= k_next;
            alpha_reg   <= alpha_next;
            beta_reg    <= beta_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            last_reg    <= last_next;
            cnt_reg     <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        j_reg     <= j_next;
        hi_reg    <= hi_next;
        v_reg     <= v_next;
        sum_reg   <= sum_next;
        acc_reg   <= acc_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        scale_reg <= scale_next;
        m_reg     <= m_next;
        p_reg     <= p_next;
        frac_reg  <= frac_next;
        q_reg     <= q_next;
        g_reg     <= g_next;
        norm_reg  <= norm_next;
    end

    // outputs
    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = (state_reg == S_OUT);
    assign m_norm_value    = norm_reg;
    assign m_scale_value   = scale_reg;
    assign m_channel_index = out_cnt_reg[11:0];
    assign m_run_end       = last_reg && (out_cnt_reg == n_reg);

endmodule

// ----- hw/rtl/clf_checker.sv -----
// ----------------------------------------------------------------------------
// clf_checker
// Port-level checks for the cross-channel lrn forward block.
// ----------------------------------------------------------------------------
module clf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_norm_value,
    input logic [31:0]        m_scale_value,
    input logic [11:0]        m_channel_index,
    input logic               m_run_end
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_norm_value) &&
        $stable(m_scale_value) && $stable(m_channel_index) && $stable(m_run_end))
        else $error("result changed while stalled");

    // no input taken while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while result pending");

    // an accepted item starts the sequencer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("ready right after accept");

    // a taken result is followed by a check cycle
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("back to back results");

    // reset leaves no result pending
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");

endmodule

bind cross_channel_lrn_forward clf_checker u_clf_checker (.*);

// ----- tb/cross_channel_lrn_forward_tb.sv -----
// ----------------------------------------------------------------------------
// cross_channel_lrn_forward_tb
// Streams channel activations into the lrn forward block under several
// register settings and random idling on both channels. Every result is
// checked field by field against a predictor that keeps its own value ring,
// channel counters and register copies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cross_channel_lrn_forward_tb;
    import clf_pkg::*;

    typedef struct {
        logic signed [15:0] norm;
        logic [31:0]        scale;
        logic [11:0]        chan;
        logic               run_end;
    } lrn_result_t;

    // directed row: typed expectations only for single-channel positions
    typedef struct {
        logic [15:0] sample;
        logic        last;
        bit          typed;
        logic [15:0] norm;
        logic [31:0] scale;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_sample_value;
    logic               s_last_channel;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_norm_value;
    logic [31:0]        m_scale_value;
    logic [11:0]        m_channel_index;
    logic               m_run_end;
    logic               cfg_wr_en;
    logic [1:0]         cfg_wr_index;
    logic [23:0]        cfg_wr_data;

    // predictor state
    logic [15:0] ring_mem [16];
    int unsigned in_chan_cnt;
    int unsigned out_chan_cnt;
    logic [3:0]  win_reg;
    logic [23:0] bias_reg;
    logic [23:0] alpha_reg;
    logic [15:0] beta_reg;
    longint unsigned exp2_roots [16];

    lrn_result_t expected_q [$];
    int items_sent;
    int results_checked;
    int mismatch_count;
    int sender_idle_pct;
    int recv_idle_pct;

    cross_channel_lrn_forward u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_value  (s_sample_value),
        .s_last_channel  (s_last_channel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_norm_value    (m_norm_value),
        .m_scale_value   (m_scale_value),
        .m_channel_index (m_channel_index),
        .m_run_end       (m_run_end),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data)
    );

    // 10 ns clock, first rising edge at 5 ns
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // digit-by-digit integer square root
    function automatic longint unsigned int_sqrt(input longint unsigned n_in);
        longint unsigned n;
        longint unsigned root;
        longint unsigned b;
        n    = n_in;
        root = 0;
        b    = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n    = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // log2(s / 2^16) as signed q.16, s nonzero
    function automatic longint log2_fix(input logic [31:0] s);
        int              msb;
        longint unsigned mant;
        longint          frac;
        msb  = 31;
        frac = 0;
        while (msb > 0 && s[msb] == 1'b0) msb--;
        mant = (msb <= 30) ? (longint'(s) << (30 - msb)) : (longint'(s) >> 1);
        for (int i = 0; i < 16; i++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd1 << 31)) begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        return longint'(msb - 16) * 65536 + frac;
    endfunction

    // 2^(f / 2^16) as q1.30
    function automatic longint unsigned exp2_fix(input logic [15:0] f);
        longint unsigned g;
        g = 64'd1 << 30;
        for (int i = 0; i < 16; i++)
            if (f[15 - i]) g = (g * exp2_roots[i]) >> 30;
        return g;
    endfunction

    function automatic logic signed [15:0] norm_of(input int x, input logic [31:0] scale,
                                                   input logic [15:0] beta);
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned r;
        longint          q;
        longint          ip;
        longint          fp;
        int              sh;
        if (x == 0) return 16'sd0;
        if (beta == 0) return x[15:0];
        mag = (x < 0) ? longint'(-x) : longint'(x);
        if (scale == 0) begin
            r = 32768;
        end else begin
            q    = (-(longint'(beta) * log2_fix(scale))) >>> 14;
            ip   = q >>> 16;
            fp   = q - ip * 65536;
            prod = mag * exp2_fix(fp[15:0]);
            if (ip >= 16) begin
                r = 32768;
            end else begin
                sh = 30 - int'(ip);
                r  = (sh >= 64) ? 0 : (prod + (64'd1 << (sh - 1))) >> sh;
            end
        end
        if (x > 0) return (r > 32767) ? 16'sd32767 : r[15:0];
        return (r > 32768) ? -16'sd32768 : -r[15:0];
    endfunction

    function automatic int ring_at(input int unsigned ch);
        return int'($signed(ring_mem[ch & 15]));
    endfunction

    // window sums for every result due after this item
    task automatic predict_lrn(input logic [15:0] sample, input logic last_in);
        int unsigned     n;
        int unsigned     w;
        int unsigned     half;
        int unsigned     o;
        int unsigned     lo;
        int unsigned     hi;
        int              cnt;
        int              v;
        bit              last;
        longint unsigned sq_sum;
        longint unsigned scale;
        lrn_result_t     res;
        n    = in_chan_cnt;
        last = last_in;
        w    = (win_reg == 0) ? 1 : win_reg;
        half = w / 2;
        cnt  = 0;
        ring_mem[n & 15] = sample;
        if (n >= MAX_CHANNELS - 1) last = 1;
        in_chan_cnt = n + 1;
        while (cnt < 8 && out_chan_cnt <= n && (last || out_chan_cnt + half <= n)) begin
            o      = out_chan_cnt;
            lo     = (o >= half) ? o - half : 0;
            hi     = (o + half < n) ? o + half : n;
            sq_sum = 0;
            v      = ring_at(o);
            for (int unsigned j = lo; j <= hi; j++)
                sq_sum += longint'(ring_at(j) * ring_at(j));
            scale = longint'(bias_reg) + ((longint'(alpha_reg) * sq_sum / w) >> 24);
            if (scale > 64'hFFFF_FFFF) scale = 64'hFFFF_FFFF;
            res.norm    = norm_of(v, scale[31:0], beta_reg);
            res.scale   = scale[31:0];
            res.chan    = o[11:0];
            res.run_end = last && o == n;
            expected_q.push_back(res);
            cnt++;
            out_chan_cnt = o + 1;
        end
        if (last) begin
            in_chan_cnt  = 0;
            out_chan_cnt = 0;
        end
    endtask

    // one item on the s_ channel, called just after a rising edge
    task automatic send_sample(input logic [15:0] sample, input logic last);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_value <= sample;
        s_last_channel <= last;
        do @(posedge aclk); while (!s_ready);
        predict_lrn(sample, last);
        items_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        case (idx)
            REG_WINDOW: win_reg   = data[3:0];
            REG_BIAS:   bias_reg  = data;
            REG_ALPHA:  alpha_reg = data;
            default:    beta_reg  = data[15:0];
        endcase
    endtask

    // wait for all results, then for a flush that may still be running
    task automatic drain;
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [3:0] w, input logic [23:0] k, input logic [23:0] a,
                            input logic [15:0] b);
        drain();
        write_reg(REG_WINDOW, {20'd0, w});
        write_reg(REG_BIAS, k);
        write_reg(REG_ALPHA, a);
        write_reg(REG_BETA, {8'd0, b});
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    // random positions; ends with a partial one so the next write lands mid-position
    task automatic send_positions(input int count);
        int len;
        int sent;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 18);
            for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
            sent += len;
        end
        repeat ($urandom_range(1, 6)) send_sample(rand_sample(), 1'b0);
    endtask

    // result side: random stall, compare at each accepted item
    always @(posedge aclk) begin
        lrn_result_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: chan %0d norm %0d scale %0h",
                                 m_channel_index, m_norm_value, m_scale_value);
                end else begin
                    exp_res = expected_q.pop_front();
                    results_checked++;
                    if (m_norm_value !== exp_res.norm || m_scale_value !== exp_res.scale ||
                        m_channel_index !== exp_res.chan || m_run_end !== exp_res.run_end) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: exp ch %0d norm %0d scale %0h end %0b",
                                     exp_res.chan, exp_res.norm, exp_res.scale,
                                     exp_res.run_end);
                            $display("          got ch %0d norm %0d scale %0h end %0b",
                                     m_channel_index, m_norm_value, m_scale_value,
                                     m_run_end);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("cross_channel_lrn_forward_tb failed");
        $finish;
    end

    // stimulus
    initial begin
        stim_row_t rows [13];
        rows[0]  = '{16'h0000, 1'b1, 1'b1, 16'h0000, 32'd131072};
        rows[1]  = '{16'h7FFF, 1'b1, 1'b0, 16'h0, 32'h0};
        rows[2]  = '{16'h8000, 1'b1, 1'b0, 16'h0, 32'h0};
        rows[3]  = '{16'h0001, 1'b1, 1'b0, 16'h0, 32'h0};
        rows[4]  = '{16'hFFFF, 1'b1, 1'b0, 16'h0, 32'h0};
        rows[5]  = '{16'h0100, 1'b0, 1'b0, 16'h0, 32'h0};
        rows[6]  = '{16'h7FFF, 1'b0, 1'b0, 16'h0, 32'h0};
        rows[7]  = '{16'h8000, 1'b0, 1'b0, 16'h0, 32'h0};
        rows[8]  = '{16'h0000, 1'b0, 1'b0, 16'h0, 32'h0};
        rows[9]  = '{16'h1234, 1'b0, 1'b0, 16'h0, 32'h0};
        rows[10] = '{16'hFF00, 1'b1, 1'b0, 16'h0, 32'h0};
        rows[11] = '{16'hAAAA, 1'b0, 1'b0, 16'h0, 32'h0};
        rows[12] = '{16'h5555, 1'b1, 1'b0, 16'h0, 32'h0};

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_sample_value  = '0;
        s_last_channel  = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_index    = REG_WINDOW;
        cfg_wr_data     = '0;
        items_sent      = 0;
        results_checked = 0;
        mismatch_count  = 0;
        sender_idle_pct = 13;
        recv_idle_pct   = 75;
        for (int i = 0; i < 16; i++) ring_mem[i] = '0;
        in_chan_cnt  = 0;
        out_chan_cnt = 0;
        win_reg      = WINDOW_RST;
        bias_reg     = BIAS_RST;
        alpha_reg    = ALPHA_RST;
        beta_reg     = BETA_RST;
        exp2_roots[0] = int_sqrt(64'd1 << 61);
        for (int i = 1; i < 16; i++) exp2_roots[i] = int_sqrt(exp2_roots[i - 1] << 30);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset defaults
        foreach (rows[i]) begin
            send_sample(rows[i].sample, rows[i].last);
            if (rows[i].typed) begin
                expected_q[expected_q.size() - 1].norm  = rows[i].norm;
                expected_q[expected_q.size() - 1].scale = rows[i].scale;
            end
        end

        // register extremes: largest bias and alpha, huge beta
        set_regs(4'd0, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        send_positions(70);
        // zero scale with nonzero beta, widest window
        set_regs(4'd15, 24'd0, 24'd0, 16'h4000);
        send_positions(70);
        set_regs(4'd15, 24'($urandom), 24'($urandom), 16'($urandom));
        send_positions(70);

        sender_idle_pct = 75;
        recv_idle_pct   = 13;
        // beta zero passes values through
        set_regs(4'd2, 24'($urandom), 24'($urandom), 16'd0);
        send_positions(70);
        set_regs(4'd1, 24'($urandom_range(0, 65535)), 24'($urandom), 16'($urandom));
        send_positions(70);

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        set_regs(4'd4, 24'($urandom_range(0, 1 << 18)), 24'($urandom_range(0, 1 << 16)),
                 16'($urandom_range(0, 1 << 14)));
        send_positions(80);
        set_regs(4'd7, 24'($urandom), 24'($urandom_range(0, 1 << 12)), 16'($urandom));
        send_positions(70);

        drain();
        $display("%0d items sent, %0d results checked over 8 register settings",
                 items_sent, results_checked);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("cross_channel_lrn_forward_tb passed");
        end else begin
            $display("cross_channel_lrn_forward_tb failed");
        end
        $finish;
    end

endmodule
